/* rtl/core/pet_pkg.sv */
package pet_pkg;

    localparam int POS_W = 5;
    localparam int SYM_W = 5;
    localparam int CNT_W = 6;
    localparam int W_W = 32;
    localparam int E_W = 48;
    localparam int ACC_W = 56;
    localparam int CFG_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [2:0] KIND_WR_FIELD = 3'd0;
    localparam logic [2:0] KIND_WR_CPL = 3'd1;
    localparam logic [2:0] KIND_WR_SEQ = 3'd2;
    localparam logic [2:0] KIND_TOTAL = 3'd3;
    localparam logic [2:0] KIND_MOVE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SYMBOLS = 1'd1;

    localparam logic [CFG_W-1:0] SEQ_LEN_RESET = 6'd32;
    localparam logic [CFG_W-1:0] NUM_SYMBOLS_RESET = 6'd21;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    typedef enum logic [2:0] {
        OP_WR_FIELD,
        OP_WR_CPL,
        OP_WR_SEQ,
        OP_TOTAL,
        OP_MOVE,
        OP_BAD_MOVE
    } op_t;

    typedef enum logic [1:0] {
        MD_WRITE,
        MD_TOTAL,
        MD_MOVE
    } mode_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CA1,
        ST_CA2,
        ST_CWR,
        ST_CRD,
        ST_CACC,
        ST_T_I,
        ST_T_SI,
        ST_T_FRD,
        ST_T_FACC,
        ST_T_J,
        ST_T_SJ,
        ST_M_OLD,
        ST_M_OLDL,
        ST_M_F1,
        ST_M_F1A,
        ST_M_F2,
        ST_M_F2A,
        ST_M_J,
        ST_M_SJ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic [W_W-1:0]   weight;
    } cmd_t;

endpackage

/* rtl/core/pet_ram.sv */
module pet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pet_cmd_fifo.sv */
module pet_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pet_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output pet_pkg::cmd_t q_data
);
    import pet_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/pet_front.sv */
module pet_front #(
    parameter int MAX_LEN = 32,
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pet_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_kind,
    input  logic [pet_pkg::POS_W-1:0]         s_pos_a,
    input  logic [pet_pkg::POS_W-1:0]         s_pos_b,
    input  logic [pet_pkg::SYM_W-1:0]         s_symbol_a,
    input  logic [pet_pkg::SYM_W-1:0]         s_symbol_b,
    input  logic signed [pet_pkg::W_W-1:0]    s_weight,
    input  logic                              clearing,
    input  logic                              q_full,
    output logic                              push,
    output pet_pkg::cmd_t                     push_data,
    output logic [pet_pkg::CNT_W-1:0]         eff_len
);
    import pet_pkg::*;

    logic [CFG_W-1:0] seq_len_reg;
    logic [CFG_W-1:0] num_symbols_reg;
    logic [CNT_W-1:0] eff_syms;
    logic             pa_ok, pb_ok, sa_ok, sb_ok, keep;
    op_t              op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg     <= SEQ_LEN_RESET;
            num_symbols_reg <= NUM_SYMBOLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEQ_LEN:     seq_len_reg <= cfg_wdata;
                REG_NUM_SYMBOLS: num_symbols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_len  = (32'(seq_len_reg) > MAX_LEN) ? CNT_W'(MAX_LEN) : seq_len_reg;
    assign eff_syms = (32'(num_symbols_reg) > MAX_SYMBOLS) ? CNT_W'(MAX_SYMBOLS)
                                                           : num_symbols_reg;

    assign pa_ok = CNT_W'(s_pos_a) < eff_len;
    assign pb_ok = CNT_W'(s_pos_b) < eff_len;
    assign sa_ok = CNT_W'(s_symbol_a) < eff_syms;
    assign sb_ok = CNT_W'(s_symbol_b) < eff_syms;

    // Bad writes and unknown kinds are taken and dropped here.
    always_comb begin
        keep = 1'b0;
        op   = OP_WR_FIELD;
        case (s_kind)
            KIND_WR_FIELD: begin
                keep = pa_ok && sa_ok;
                op   = OP_WR_FIELD;
            end
            KIND_WR_CPL: begin
                keep = (s_pos_a < s_pos_b) && pb_ok && sa_ok && sb_ok;
                op   = OP_WR_CPL;
            end
            KIND_WR_SEQ: begin
                keep = pa_ok && sa_ok;
                op   = OP_WR_SEQ;
            end
            KIND_TOTAL: begin
                keep = 1'b1;
                op   = OP_TOTAL;
            end
            KIND_MOVE: begin
                keep = 1'b1;
                op   = (pa_ok && sa_ok) ? OP_MOVE : OP_BAD_MOVE;
            end
            default: begin
                keep = 1'b0;
                op   = OP_WR_FIELD;
            end
        endcase
    end

    assign s_ready = !clearing && !q_full;
    assign push    = s_valid && s_ready && keep;

    assign push_data.op     = op;
    assign push_data.pos_a  = s_pos_a;
    assign push_data.pos_b  = s_pos_b;
    assign push_data.sym_a  = s_symbol_a;
    assign push_data.sym_b  = s_symbol_b;
    assign push_data.weight = s_weight;

endmodule

/* rtl/core/pet_back.sv */
module pet_back #(
    parameter int MAX_LEN = 32,
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pet_pkg::CNT_W-1:0]     eff_len,
    input  logic                          q_valid,
    input  pet_pkg::cmd_t                 q_data,
    output logic                          pop,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [pet_pkg::E_W-1:0] m_energy,
    output logic                          m_query_kind,
    output logic [1:0]                    m_status
);
    import pet_pkg::*;

    localparam int PAIRS     = (MAX_LEN * (MAX_LEN - 1)) / 2;
    localparam int FLD_DEPTH = MAX_SYMBOLS * MAX_LEN;
    localparam int CPL_DEPTH = MAX_SYMBOLS * MAX_SYMBOLS * PAIRS;
    localparam int FA_W      = $clog2(FLD_DEPTH);
    localparam int CA_W      = $clog2(CPL_DEPTH);
    localparam int SQ_W      = $clog2(MAX_LEN);
    localparam int SR_W      = $clog2(MAX_SYMBOLS * MAX_SYMBOLS);
    localparam int PR_W      = $clog2(2 * MAX_LEN * MAX_LEN);
    localparam int CLR_W     = $clog2(CPL_DEPTH + 1);

    localparam logic signed [ACC_W-1:0] E_MAX_A = {{(ACC_W-E_W+1){1'b0}}, {(E_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] E_MIN_A = {{(ACC_W-E_W+1){1'b1}}, {(E_W-1){1'b0}}};

    state_t                   state_reg, state_next;
    mode_t                    mode_reg;
    cmd_t                     cmd_reg;
    logic [CLR_W-1:0]         clr_reg;
    logic [CNT_W-1:0]         i_reg, j_reg;
    logic [SYM_W-1:0]         si_reg, sj_reg, old_reg;
    logic                     term_reg, sub_reg, bad_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [PR_W-1:0]          prod_reg;
    logic [SR_W-1:0]          symrow_reg;
    logic [CA_W-1:0]          addr_reg;
    logic                     out_valid_reg;
    logic signed [E_W-1:0]    energy_reg;
    logic                     qk_reg;
    logic [1:0]               status_reg;

    logic [CNT_W-1:0]         pa;
    logic [SYM_W-1:0]         mine, ca_x, ca_y;
    logic [CNT_W-1:0]         ca_lo, ca_hi;
    logic                     emit_fire;
    logic signed [ACC_W-1:0]  fld_val, cpl_val;

    logic                     fld_we, seq_we, cpl_we;
    logic [FA_W-1:0]          fld_waddr, fld_raddr;
    logic [W_W-1:0]           fld_wdata, fld_rdata;
    logic [SQ_W-1:0]          seq_waddr, seq_raddr;
    logic [SYM_W-1:0]         seq_wdata, seq_rdata;
    logic [CA_W-1:0]          cpl_waddr;
    logic [W_W-1:0]           cpl_wdata, cpl_rdata;

    function automatic logic [FA_W-1:0] field_addr(input logic [SYM_W-1:0] s,
                                                   input logic [CNT_W-1:0] p);
        field_addr = FA_W'(FA_W'(s) * FA_W'(MAX_LEN) + FA_W'(p));
    endfunction

    assign pa        = CNT_W'(cmd_reg.pos_a);
    assign mine      = term_reg ? cmd_reg.sym_a : old_reg;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);
    assign fld_val   = ACC_W'($signed(fld_rdata));
    assign cpl_val   = ACC_W'($signed(cpl_rdata));

    // Operands of the coupling address unit.
    always_comb begin
        ca_x  = cmd_reg.sym_a;
        ca_y  = cmd_reg.sym_b;
        ca_lo = CNT_W'(cmd_reg.pos_a);
        ca_hi = CNT_W'(cmd_reg.pos_b);
        case (mode_reg)
            MD_WRITE: ;
            MD_TOTAL: begin
                ca_x  = si_reg;
                ca_y  = sj_reg;
                ca_lo = i_reg;
                ca_hi = j_reg;
            end
            MD_MOVE: begin
                if (j_reg < pa) begin
                    ca_x  = sj_reg;
                    ca_y  = mine;
                    ca_lo = j_reg;
                    ca_hi = pa;
                end else begin
                    ca_x  = mine;
                    ca_y  = sj_reg;
                    ca_lo = pa;
                    ca_hi = j_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CLR_W'(CPL_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_data.op)
                        OP_WR_CPL:   state_next = ST_CA1;
                        OP_TOTAL:    state_next = ST_T_I;
                        OP_MOVE:     state_next = ST_M_OLD;
                        OP_BAD_MOVE: state_next = ST_EMIT;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CA1:    state_next = ST_CA2;
            ST_CA2:    state_next = (mode_reg == MD_WRITE) ? ST_CWR : ST_CRD;
            ST_CWR:    state_next = ST_IDLE;
            ST_CRD:    state_next = ST_CACC;
            ST_CACC: begin
                if (mode_reg == MD_TOTAL) begin
                    state_next = ST_T_J;
                end else begin
                    state_next = term_reg ? ST_M_J : ST_CA1;
                end
            end
            ST_T_I:    state_next = (i_reg == eff_len) ? ST_EMIT : ST_T_SI;
            ST_T_SI:   state_next = ST_T_FRD;
            ST_T_FRD:  state_next = ST_T_FACC;
            ST_T_FACC: state_next = ST_T_J;
            ST_T_J:    state_next = (j_reg == eff_len) ? ST_T_I : ST_T_SJ;
            ST_T_SJ:   state_next = ST_CA1;
            ST_M_OLD:  state_next = ST_M_OLDL;
            ST_M_OLDL: state_next = ST_M_F1;
            ST_M_F1:   state_next = ST_M_F1A;
            ST_M_F1A:  state_next = ST_M_F2;
            ST_M_F2:   state_next = ST_M_F2A;
            ST_M_F2A:  state_next = ST_M_J;
            ST_M_J: begin
                if (j_reg == eff_len) begin
                    state_next = ST_EMIT;
                end else if (j_reg != pa) begin
                    state_next = ST_M_SJ;
                end
            end
            ST_M_SJ:   state_next = ST_CA1;
            ST_EMIT:   if (emit_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory port controls and handshake outputs.
    always_comb begin
        pop       = 1'b0;
        fld_we    = 1'b0;
        seq_we    = 1'b0;
        cpl_we    = 1'b0;
        fld_waddr = field_addr(q_data.sym_a, CNT_W'(q_data.pos_a));
        fld_wdata = q_data.weight;
        seq_waddr = SQ_W'(q_data.pos_a);
        seq_wdata = q_data.sym_a;
        cpl_waddr = addr_reg;
        cpl_wdata = cmd_reg.weight;
        fld_raddr = field_addr(si_reg, i_reg);
        seq_raddr = SQ_W'(j_reg);
        case (state_reg)
            ST_CLEAR: begin
                fld_we    = 32'(clr_reg) < FLD_DEPTH;
                seq_we    = 32'(clr_reg) < MAX_LEN;
                cpl_we    = 1'b1;
                fld_waddr = clr_reg[FA_W-1:0];
                seq_waddr = clr_reg[SQ_W-1:0];
                cpl_waddr = clr_reg[CA_W-1:0];
                fld_wdata = '0;
                seq_wdata = '0;
                cpl_wdata = '0;
            end
            ST_IDLE: begin
                pop    = q_valid;
                fld_we = q_valid && (q_data.op == OP_WR_FIELD);
                seq_we = q_valid && (q_data.op == OP_WR_SEQ);
            end
            ST_CWR:   cpl_we = 1'b1;
            ST_T_I:   seq_raddr = SQ_W'(i_reg);
            ST_M_OLD: seq_raddr = SQ_W'(pa);
            ST_M_F1:  fld_raddr = field_addr(old_reg, pa);
            ST_M_F2:  fld_raddr = field_addr(cmd_reg.sym_a, pa);
            default: ;
        endcase
    end

    assign clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_reg  <= q_data;
                    acc_reg  <= '0;
                    i_reg    <= '0;
                    term_reg <= 1'b0;
                    bad_reg  <= (q_data.op == OP_BAD_MOVE);
                    if (q_data.op == OP_TOTAL) begin
                        mode_reg <= MD_TOTAL;
                    end else if (q_data.op == OP_MOVE || q_data.op == OP_BAD_MOVE) begin
                        mode_reg <= MD_MOVE;
                    end else begin
                        mode_reg <= MD_WRITE;
                    end
                end
            end
            ST_CA1: begin
                prod_reg   <= PR_W'(PR_W'(ca_lo) * (PR_W'(2 * MAX_LEN - 3) - PR_W'(ca_lo)));
                symrow_reg <= SR_W'(SR_W'(ca_x) * SR_W'(MAX_SYMBOLS) + SR_W'(ca_y));
                sub_reg    <= (mode_reg == MD_TOTAL) || term_reg;
            end
            ST_CA2: begin
                addr_reg <= CA_W'(CA_W'(symrow_reg) * CA_W'(PAIRS) + CA_W'(prod_reg >> 1)
                                  + CA_W'(ca_hi) - 1'b1);
            end
            ST_CACC: begin
                acc_reg <= sub_reg ? acc_reg - cpl_val : acc_reg + cpl_val;
                if (mode_reg == MD_TOTAL) begin
                    j_reg <= j_reg + 1'b1;
                end else if (term_reg) begin
                    term_reg <= 1'b0;
                    j_reg    <= j_reg + 1'b1;
                end else begin
                    term_reg <= 1'b1;
                end
            end
            ST_T_SI:   si_reg <= seq_rdata;
            ST_T_FACC: begin
                acc_reg <= acc_reg - fld_val;
                j_reg   <= i_reg + 1'b1;
            end
            ST_T_J:    if (j_reg == eff_len) i_reg <= i_reg + 1'b1;
            ST_T_SJ:   sj_reg <= seq_rdata;
            ST_M_OLDL: old_reg <= seq_rdata;
            ST_M_F1A:  acc_reg <= acc_reg + fld_val;
            ST_M_F2A: begin
                acc_reg <= acc_reg - fld_val;
                j_reg   <= '0;
            end
            ST_M_J:    if (j_reg != eff_len && j_reg == pa) j_reg <= j_reg + 1'b1;
            ST_M_SJ:   sj_reg <= seq_rdata;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            qk_reg <= (mode_reg == MD_MOVE);
            if (bad_reg) begin
                energy_reg <= '0;
                status_reg <= STATUS_RANGE;
            end else if (acc_reg > E_MAX_A) begin
                energy_reg <= E_MAX_A[E_W-1:0];
                status_reg <= STATUS_SAT;
            end else if (acc_reg < E_MIN_A) begin
                energy_reg <= E_MIN_A[E_W-1:0];
                status_reg <= STATUS_SAT;
            end else begin
                energy_reg <= acc_reg[E_W-1:0];
                status_reg <= STATUS_OK;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_energy     = energy_reg;
    assign m_query_kind = qk_reg;
    assign m_status     = status_reg;

    pet_ram #(.WIDTH(W_W), .DEPTH(FLD_DEPTH)) u_field_ram (
        .aclk  (aclk),
        .we    (fld_we),
        .waddr (fld_waddr),
        .wdata (fld_wdata),
        .raddr (fld_raddr),
        .rdata (fld_rdata)
    );

    pet_ram #(.WIDTH(W_W), .DEPTH(CPL_DEPTH)) u_coupling_ram (
        .aclk  (aclk),
        .we    (cpl_we),
        .waddr (cpl_waddr),
        .wdata (cpl_wdata),
        .raddr (addr_reg),
        .rdata (cpl_rdata)
    );

    pet_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seq_ram (
        .aclk  (aclk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    // The front takes no word while the tables are being cleared.
    a_clear_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !q_valid)
        else $error("command queued during clearing pass");

    a_pair_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CA1 |-> ca_lo < ca_hi)
        else $error("coupling pair not ordered");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg == STATUS_SAT) |->
            (energy_reg == E_MAX_A[E_W-1:0] || energy_reg == E_MIN_A[E_W-1:0]))
        else $error("saturated result not at a range limit");

endmodule

/* rtl/core/potts_energy_engine_core.sv */
// Potts-model energy engine.
// Input words arrive on the s_ channel (valid/ready) and carry one of five
// operations: write a field weight, write a coupling weight, write a sequence
// symbol, ask for the total energy, or ask for the energy change of a move.
// Only the two queries return a word on the m_ channel (valid/ready).
// The cfg_ port writes seq_len or num_symbols, chosen by cfg_index, with no
// handshake. A front stage checks each word and puts the kept ones in a
// four-entry command queue; a back sequencer works through one command at a
// time. Every coupling access goes through the address unit (states CA1 and
// CA2) and one read of the single read port of the coupling memory.
// The sequencer handles one command at a time.
// After reset a clearing pass zeroes all tables, one entry per cycle; s_ready
// stays low for the whole pass. A result waits in the output register while
// m_ready is low; the queue keeps taking words until it fills.
module potts_energy_engine_core #(
    parameter int MAX_LEN = 32,
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pet_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_kind,
    input  logic [pet_pkg::POS_W-1:0]          s_pos_a,
    input  logic [pet_pkg::POS_W-1:0]          s_pos_b,
    input  logic [pet_pkg::SYM_W-1:0]          s_symbol_a,
    input  logic [pet_pkg::SYM_W-1:0]          s_symbol_b,
    input  logic signed [pet_pkg::W_W-1:0]     s_weight,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pet_pkg::E_W-1:0]     m_energy,
    output logic                               m_query_kind,
    output logic [1:0]                         m_status
);
    import pet_pkg::*;

    cmd_t             push_data, q_data;
    logic             push, q_full, pop, q_valid, clearing;
    logic [CNT_W-1:0] eff_len;

    pet_front #(.MAX_LEN(MAX_LEN), .MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_pos_a    (s_pos_a),
        .s_pos_b    (s_pos_b),
        .s_symbol_a (s_symbol_a),
        .s_symbol_b (s_symbol_b),
        .s_weight   (s_weight),
        .clearing   (clearing),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data),
        .eff_len    (eff_len)
    );

    pet_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    pet_back #(.MAX_LEN(MAX_LEN), .MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_len      (eff_len),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_energy     (m_energy),
        .m_query_kind (m_query_kind),
        .m_status     (m_status)
    );

endmodule

/* test/potts_energy_engine_core_tb.sv */
`timescale 1ns / 1ps

module potts_energy_engine_core_tb;
    import pet_pkg::*;

    localparam int LEN = 32;
    localparam int SYMS = 32;
    localparam int PAIRS = LEN * (LEN - 1) / 2;
    localparam int CYCLE_LIMIT = 20000000;
    localparam longint E_HI = 64'sd140737488355327;
    localparam longint E_LO = -64'sd140737488355328;

    typedef struct {
        logic [2:0]        kind;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [SYM_W-1:0]  sym_a;
        logic [SYM_W-1:0]  sym_b;
        logic [W_W-1:0]    weight;
        bit                typed;
        logic [E_W-1:0]    t_energy;
        logic              t_qk;
        logic [1:0]        t_status;
    } word_t;

    typedef struct {
        logic [E_W-1:0] energy;
        logic           qk;
        logic [1:0]     status;
    } answer_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic [POS_W-1:0] s_pos_a = '0;
    logic [POS_W-1:0] s_pos_b = '0;
    logic [SYM_W-1:0] s_symbol_a = '0;
    logic [SYM_W-1:0] s_symbol_b = '0;
    logic signed [W_W-1:0] s_weight = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [E_W-1:0] m_energy;
    logic m_query_kind;
    logic [1:0] m_status;

    potts_energy_engine_core dut (.*);

    always #5 aclk = ~aclk;

    // Shadow copy of the engine state.
    int field_w [SYMS*LEN];
    int coupling_w [int];
    logic [SYM_W-1:0] seq_sym [LEN];
    int cur_len = SEQ_LEN_RESET;
    int cur_syms = NUM_SYMBOLS_RESET;

    answer_t pending_answers[$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold = 0;
    longint cycles = 0;

    function automatic int eff_len();
        return cur_len > LEN ? LEN : cur_len;
    endfunction

    function automatic int eff_syms();
        return cur_syms > SYMS ? SYMS : cur_syms;
    endfunction

    function automatic int cpl_addr(int sa, int sb, int i, int j);
        return (sa * SYMS + sb) * PAIRS + j - 1 + (i * (2 * LEN - 3 - i)) / 2;
    endfunction

    function automatic longint cpl_at(int sa, int sb, int i, int j);
        int a;
        a = cpl_addr(sa, sb, i, j);
        return coupling_w.exists(a) ? longint'(coupling_w[a]) : 0;
    endfunction

    function automatic answer_t make_answer(longint e, logic qk, logic [1:0] st);
        answer_t r;
        if (e > E_HI) begin e = E_HI; st = STATUS_SAT; end
        if (e < E_LO) begin e = E_LO; st = STATUS_SAT; end
        r.energy = e[E_W-1:0];
        r.qk = qk;
        r.status = st;
        return r;
    endfunction

    // Updates the shadow state; returns 1 with the answer for queries.
    function automatic bit energy_step(word_t w, output answer_t ans);
        int n, q, pa, pb, sa, sb, old, i, j;
        longint e;
        n = eff_len();
        q = eff_syms();
        pa = int'(w.pos_a);
        pb = int'(w.pos_b);
        sa = int'(w.sym_a);
        sb = int'(w.sym_b);
        e = 0;
        case (w.kind)
            KIND_WR_FIELD: begin
                if (pa < n && sa < q) field_w[sa*LEN+pa] = w.weight;
                return 0;
            end
            KIND_WR_CPL: begin
                if (pa < pb && pb < n && sa < q && sb < q)
                    coupling_w[cpl_addr(sa, sb, pa, pb)] = w.weight;
                return 0;
            end
            KIND_WR_SEQ: begin
                if (pa < n && sa < q) seq_sym[pa] = w.sym_a;
                return 0;
            end
            KIND_TOTAL: begin
                for (i = 0; i < n; i++) begin
                    e -= field_w[seq_sym[i]*LEN+i];
                    for (j = i + 1; j < n; j++) e -= cpl_at(seq_sym[i], seq_sym[j], i, j);
                end
                ans = make_answer(e, 1'b0, STATUS_OK);
                return 1;
            end
            KIND_MOVE: begin
                if (pa >= n || sa >= q) begin
                    ans = make_answer(0, 1'b1, STATUS_RANGE);
                    return 1;
                end
                old = int'(seq_sym[pa]);
                e = longint'(field_w[old*LEN+pa]) - field_w[sa*LEN+pa];
                for (j = 0; j < pa; j++)
                    e += cpl_at(seq_sym[j], old, j, pa) - cpl_at(seq_sym[j], sa, j, pa);
                for (j = pa + 1; j < n; j++)
                    e += cpl_at(old, seq_sym[j], pa, j) - cpl_at(sa, seq_sym[j], pa, j);
                ans = make_answer(e, 1'b1, STATUS_OK);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_word(word_t w);
        answer_t a;
        s_valid <= 1'b1;
        s_kind <= w.kind;
        s_pos_a <= w.pos_a;
        s_pos_b <= w.pos_b;
        s_symbol_a <= w.sym_a;
        s_symbol_b <= w.sym_b;
        s_weight <= w.weight;
        do @(posedge aclk); while (!s_ready);
        if (energy_step(w, a)) begin
            if (w.typed) begin
                a.energy = w.t_energy;
                a.qk = w.t_qk;
                a.status = w.t_status;
            end
            pending_answers.push_back(a);
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop offering words until every answer is back and queued writes settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_SEQ_LEN) cur_len = value & 63;
        else cur_syms = value & 63;
    endtask

    function automatic word_t mk(logic [2:0] k, int pa, int pb, int sa, int sb, int w);
        word_t r;
        r.kind = k;
        r.pos_a = POS_W'(pa);
        r.pos_b = POS_W'(pb);
        r.sym_a = SYM_W'(sa);
        r.sym_b = SYM_W'(sb);
        r.weight = w;
        r.typed = 0;
        r.t_energy = '0;
        r.t_qk = 0;
        r.t_status = STATUS_OK;
        return r;
    endfunction

    function automatic word_t mk_typed(word_t r, logic qk, logic [1:0] st);
        r.typed = 1;
        r.t_qk = qk;
        r.t_status = st;
        return r;
    endfunction

    function automatic int pick(int lim, bit good);
        if (good && lim > 0) return $urandom_range(lim - 1);
        return $urandom_range(31);
    endfunction

    // Mostly in-range writes and moves; some noise, rare totals on long sequences.
    function automatic word_t random_word();
        int n, q, r, pa, pb;
        bit good;
        word_t w;
        n = eff_len();
        q = eff_syms();
        r = $urandom_range(99);
        good = $urandom_range(9) != 0;
        w = mk(KIND_WR_FIELD, pick(n, good), pick(n, good), pick(q, good), pick(q, good),
               $urandom());
        if (r < 25) begin
            w.kind = KIND_WR_FIELD;
        end else if (r < 50) begin
            w.kind = KIND_WR_CPL;
            if (good && n >= 2) begin
                pa = $urandom_range(n - 2);
                pb = $urandom_range(pa + 1, n - 1);
                w.pos_a = POS_W'(pa);
                w.pos_b = POS_W'(pb);
            end
        end else if (r < 68) begin
            w.kind = KIND_WR_SEQ;
        end else if (r < 92) begin
            w.kind = KIND_MOVE;
        end else if (r < 96) begin
            w.kind = (n <= 16 || $urandom_range(3) == 0) ? KIND_TOTAL : KIND_MOVE;
        end else begin
            w.kind = 3'($urandom_range(5, 7));
        end
        return w;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls, long hold-off on request, in-order check.
    always @(posedge aclk) begin
        answer_t x;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", m_energy, 0);
            end else begin
                x = pending_answers.pop_front();
                if (m_energy !== x.energy) report_mismatch("energy", m_energy, x.energy);
                if (m_query_kind !== x.qk) report_mismatch("query_kind", m_query_kind, x.qk);
                if (m_status !== x.status) report_mismatch("status", m_status, x.status);
            end
        end
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        word_t plan[$];
        int lens[8] = '{32, 8, 2, 63, 1, 0, 12, 5};
        int syms[8] = '{21, 2, 32, 63, 3, 7, 2, 32};
        int count[8] = '{260, 260, 180, 200, 60, 60, 300, 280};
        int tx_pct[4] = '{0, 60, 0, 11};
        int rx_pct[4] = '{0, 0, 60, 11};
        int ph, k;

        foreach (field_w[i]) field_w[i] = 0;
        foreach (seq_sym[i]) seq_sym[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, every operation, dropped writes, unknown kinds, bad moves.
        plan.push_back(mk_typed(mk(KIND_TOTAL, 0, 0, 0, 0, 0), 1'b0, STATUS_OK));
        plan.push_back(mk_typed(mk(KIND_MOVE, 31, 0, 20, 0, 0), 1'b1, STATUS_OK));
        plan.push_back(mk_typed(mk(KIND_MOVE, 0, 0, 21, 0, 0), 1'b1, STATUS_RANGE));
        plan.push_back(mk_typed(mk(KIND_MOVE, 31, 31, 31, 31, -1), 1'b1, STATUS_RANGE));
        plan.push_back(mk(KIND_WR_FIELD, 0, 0, 0, 0, 32'h7fffffff));
        plan.push_back(mk(KIND_WR_FIELD, 31, 0, 20, 0, 32'h80000000));
        plan.push_back(mk(KIND_WR_FIELD, 3, 0, 31, 0, 32'h12345678));
        plan.push_back(mk(KIND_WR_CPL, 0, 31, 20, 20, 32'h80000000));
        plan.push_back(mk(KIND_WR_CPL, 0, 1, 0, 0, 32'h7fffffff));
        plan.push_back(mk(KIND_WR_CPL, 4, 4, 1, 1, 32'h00010000));
        plan.push_back(mk(KIND_WR_CPL, 5, 3, 1, 1, 32'h00010000));
        plan.push_back(mk(KIND_WR_CPL, 2, 9, 21, 0, 32'h00010000));
        plan.push_back(mk(KIND_WR_SEQ, 31, 0, 20, 0, 0));
        plan.push_back(mk(KIND_WR_SEQ, 1, 0, 25, 0, 0));
        plan.push_back(mk(3'd5, 1, 2, 3, 4, -1));
        plan.push_back(mk(3'd6, 1, 2, 3, 4, -1));
        plan.push_back(mk(3'd7, 31, 31, 31, 31, -1));
        plan.push_back(mk(KIND_TOTAL, 0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_MOVE, 0, 0, 20, 0, 0));
        plan.push_back(mk(KIND_MOVE, 31, 0, 0, 0, 0));
        plan.push_back(mk(KIND_MOVE, 1, 0, 20, 0, 0));
        foreach (plan[i]) send_word(plan[i]);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            write_reg(REG_SEQ_LEN, lens[ph]);
            write_reg(REG_NUM_SYMBOLS, syms[ph]);
            tx_idle_pct = tx_pct[ph % 4];
            rx_stall_pct = rx_pct[ph % 4];
            if (ph == 1) begin
                // Hold the result side long enough to fill the command queue.
                fork
                    begin
                        rx_hold = 1;
                        repeat (3000) @(posedge aclk);
                        rx_hold = 0;
                    end
                join_none
            end
            for (k = 0; k < count[ph]; k++) send_word(random_word());
            drain();
        end

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
